[rtl/pid_controller_filtered_derivative_defines.svh]
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion helpers, clocked on clk with rst_n low disabling.
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_FILTERED_DERIVATIVE_DEFINES_SVH
`define PID_CONTROLLER_FILTERED_DERIVATIVE_DEFINES_SVH

// same-cycle implication
`define PIDFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PIDFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pidfd_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Fixed-point widths and register map shared by the controller files.
// ----------------------------------------------------------------------------
`default_nettype none
package pidfd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int DW        = 50;  // magnitude width of divide dividends
  localparam int PW        = 66;  // product accumulator width
  localparam int KP_W      = 16;
  localparam int AW        = 5;   // cfg address width

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_TI   = 3'd1,
    REG_TD   = 3'd2,
    REG_LIM  = 3'd3,
    REG_N    = 3'd4
  } reg_idx_t;
endpackage
`default_nettype wire

[rtl/pidfd_if.sv]
// ----------------------------------------------------------------------------
// PID controller channel interfaces
// Valid/ready request channels for input samples and drive results.
// ----------------------------------------------------------------------------
`default_nettype none
interface pidfd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_value;
  logic signed [15:0] measured_value;
  logic        [15:0] elapsed_ms;
  modport source (output valid, target_value, measured_value, elapsed_ms, input ready);
  modport sink   (input valid, target_value, measured_value, elapsed_ms, output ready);
endinterface

interface pidfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive_value;
  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface
`default_nettype wire

[rtl/pid_controller_filtered_derivative.sv]
// ----------------------------------------------------------------------------
// PID controller, derivative on measurement with averaging filter
// Q16.16 PID with clamped integral, EMA-filtered derivative and Kp output.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request of setpoint, measurement and elapsed ms (valid/ready).
//   out_ch : one drive_value request per input, signed Q16.16, saturated.
//   cfg_*  : APB-style write/read of Kp, Ti, Td, integral limit and N at
//            byte addresses 0, 4, 8, 12, 16. pready is tied high.
// Sequencing:
//   All arithmetic runs through one shift-add multiply / restoring divide
//   unit, one bit per cycle. The integral steps are skipped when Ti is 0,
//   the derivative steps when Td or elapsed ms is 0, and the filter divide
//   when N <= 1.
//   in_ch.ready is high only while the sequencer is idle; one request is
//   processed at a time, so a new request waits until the last one is done.
// Reset: synchronous active-low rst_n clears the registers to their reset
//   values (Kp = 1.0) and clears integral, derivative and last measurement.
// Stall: the result sits in an output register; a new request is accepted
//   and computed meanwhile, and holds in its final step until out_ch frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pid_controller_filtered_derivative_defines.svh"
module pid_controller_filtered_derivative
  import pidfd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  pidfd_in_if.sink              in_ch,
  pidfd_out_if.source           out_ch,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [AW-1:0]    cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic      [31:0]      cfg_prdata,
  output logic                  cfg_pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_ISET, S_IMUL, S_IDVS, S_IDIV, S_IACC, S_DSET, S_DMUL,
    S_DDVS, S_DDIV, S_DRAW, S_FDIV, S_FUPD, S_OSET, S_OMUL, S_OSAT
  } state_t;

  localparam logic [5:0] MUL_LAST = 6'(KP_W - 1);
  localparam logic [5:0] DIV_LAST = 6'(DW - 1);
  localparam logic signed [DW:0] D_MAX = (DW+1)'((64'sd1 <<< 47) - 64'sd1);
  localparam logic signed [DW:0] D_MIN = -(DW+1)'(64'sd1 <<< 47);

  state_t state_r, state_nxt;
  logic [15:0] kp_r, ti_r, td_r;
  logic [30:0] lim_r;
  logic [7:0]  n_r;
  logic signed [16:0] err_r, err_nxt;
  logic signed [15:0] meas_r, meas_nxt, prev_r, prev_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic signed [31:0] isum_r, isum_nxt;
  logic signed [47:0] fd_r, fd_nxt;
  logic neg_r, neg_nxt;
  logic [PW-1:0] acc_r, acc_nxt, opa_r, opa_nxt;
  logic [15:0] opb_r, opb_nxt;
  logic [DW-1:0] q_r, q_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] out_data_r, out_data_nxt;

  logic cfg_wr;
  logic [PW-1:0] mul_sum;
  logic [16:0] rem_sh, rem_nx;
  logic div_ge;
  logic signed [DW:0] q_s, i_acc, lim_s, raw_w;
  logic [16:0] err_mag, diff_mag;
  logic signed [16:0] diff_c;
  logic signed [47:0] raw_c;
  logic signed [48:0] f_diff;
  logic [48:0] f_mag;
  logic signed [DW-1:0] sum_c;
  logic [DW-1:0] sum_mag;
  logic [PW-9:0] o_mag;
  logic signed [31:0] drive_c;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (reg_idx_t'(cfg_paddr[4:2]))
      REG_KP:  cfg_prdata = {16'd0, kp_r};
      REG_TI:  cfg_prdata = {16'd0, ti_r};
      REG_TD:  cfg_prdata = {16'd0, td_r};
      REG_LIM: cfg_prdata = {1'b0, lim_r};
      REG_N:   cfg_prdata = {24'd0, n_r};
      default: cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= 16'd256;
      ti_r  <= 16'd0;
      td_r  <= 16'd0;
      lim_r <= 31'd0;
      n_r   <= 8'd0;
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[4:2]))
        REG_KP:  kp_r  <= cfg_pwdata[15:0];
        REG_TI:  ti_r  <= cfg_pwdata[15:0];
        REG_TD:  td_r  <= cfg_pwdata[15:0];
        REG_LIM: lim_r <= cfg_pwdata[30:0];
        REG_N:   n_r   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // shared shift-add / restoring-divide unit
  assign mul_sum = acc_r + (opb_r[0] ? opa_r : '0);
  assign rem_sh  = {acc_r[15:0], opa_r[DW-1]};
  assign div_ge  = rem_sh >= {1'b0, opb_r};
  assign rem_nx  = div_ge ? rem_sh - {1'b0, opb_r} : rem_sh;
  assign q_s     = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

  assign err_mag  = err_r[16] ? 17'(-err_r) : 17'(err_r);
  assign diff_c   = {meas_r[15], meas_r} - {prev_r[15], prev_r};
  assign diff_mag = diff_c[16] ? 17'(-diff_c) : 17'(diff_c);

  assign lim_s = $signed({{(DW+1-31){1'b0}}, lim_r});
  assign i_acc = $signed({{(DW+1-32){isum_r[31]}}, isum_r}) + q_s;

  assign raw_w = (q_s > D_MAX) ? D_MAX : (q_s < D_MIN) ? D_MIN : q_s;
  assign raw_c = raw_w[47:0];
  assign f_diff = {raw_c[47], raw_c} - {fd_r[47], fd_r};
  assign f_mag  = f_diff[48] ? 49'(-f_diff) : 49'(f_diff);

  assign sum_c = $signed({{(DW-17-FRAC_BITS){err_r[16]}}, err_r, {FRAC_BITS{1'b0}}})
               + $signed({{(DW-32){isum_r[31]}}, isum_r})
               + $signed({{(DW-48){fd_r[47]}}, fd_r});
  assign sum_mag = sum_c[DW-1] ? DW'(-sum_c) : DW'(sum_c);

  assign o_mag = acc_r[PW-1:8];
  always_comb begin
    if (neg_r) begin
      drive_c = (o_mag > (PW-8)'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(o_mag[31:0]);
    end else begin
      drive_c = (o_mag > (PW-8)'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(o_mag[31:0]);
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.drive_value = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    meas_nxt      = meas_r;
    dt_nxt        = dt_r;
    prev_nxt      = prev_r;
    isum_nxt      = isum_r;
    fd_nxt        = fd_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    q_nxt         = q_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          err_nxt   = {in_ch.target_value[15], in_ch.target_value}
                    - {in_ch.measured_value[15], in_ch.measured_value};
          meas_nxt  = in_ch.measured_value;
          dt_nxt    = in_ch.elapsed_ms;
          state_nxt = S_ISET;
        end
      end
      S_ISET: begin
        if (ti_r == 16'd0) begin
          isum_nxt  = '0;
          state_nxt = S_DSET;
        end else begin
          opa_nxt   = PW'(err_mag);
          opb_nxt   = dt_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          neg_nxt   = err_r[16];
          state_nxt = S_IMUL;
        end
      end
      S_IMUL, S_DMUL, S_OMUL: begin
        acc_nxt = mul_sum;
        opa_nxt = {opa_r[PW-2:0], 1'b0};
        opb_nxt = {1'b0, opb_r[15:1]};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == MUL_LAST) begin
          state_nxt = (state_r == S_IMUL) ? S_IDVS :
                      (state_r == S_DMUL) ? S_DDVS : S_OSAT;
        end
      end
      S_IDVS, S_DDVS: begin
        opa_nxt   = PW'({acc_r[DW-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}});
        opb_nxt   = (state_r == S_IDVS) ? ti_r : dt_r;
        acc_nxt   = '0;
        q_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = (state_r == S_IDVS) ? S_IDIV : S_DDIV;
      end
      S_IDIV, S_DDIV, S_FDIV: begin
        acc_nxt = PW'(rem_nx);
        opa_nxt = {opa_r[PW-2:0], 1'b0};
        q_nxt   = {q_r[DW-2:0], div_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = (state_r == S_IDIV) ? S_IACC :
                      (state_r == S_DDIV) ? S_DRAW : S_FUPD;
        end
      end
      S_IACC: begin
        if (i_acc > lim_s) begin
          isum_nxt = 32'(lim_s);
        end else if (i_acc < -lim_s) begin
          isum_nxt = 32'(-lim_s);
        end else begin
          isum_nxt = 32'(i_acc);
        end
        state_nxt = S_DSET;
      end
      S_DSET: begin
        if (td_r == 16'd0) begin
          fd_nxt    = '0;
          state_nxt = S_OSET;
        end else if (dt_r == 16'd0) begin
          fd_nxt    = '0;
          prev_nxt  = meas_r;
          state_nxt = S_OSET;
        end else begin
          opa_nxt   = PW'(diff_mag);
          opb_nxt   = td_r;
          acc_nxt   = '0;
          cnt_nxt   = '0;
          neg_nxt   = ~diff_c[16];
          state_nxt = S_DMUL;
        end
      end
      S_DRAW: begin
        prev_nxt = meas_r;
        if (n_r > 8'd1) begin
          opa_nxt   = PW'(f_mag);
          opb_nxt   = {8'd0, n_r};
          neg_nxt   = f_diff[48];
          acc_nxt   = '0;
          q_nxt     = '0;
          cnt_nxt   = '0;
          state_nxt = S_FDIV;
        end else begin
          fd_nxt    = raw_c;
          state_nxt = S_OSET;
        end
      end
      S_FUPD: begin
        fd_nxt    = fd_r + q_s[47:0];
        state_nxt = S_OSET;
      end
      S_OSET: begin
        opa_nxt   = PW'(sum_mag);
        opb_nxt   = kp_r;
        neg_nxt   = sum_c[DW-1];
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_OMUL;
      end
      S_OSAT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = drive_c;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      isum_r      <= '0;
      fd_r        <= '0;
      prev_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      isum_r      <= isum_nxt;
      fd_r        <= fd_nxt;
      prev_r      <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r      <= err_nxt;
    meas_r     <= meas_nxt;
    dt_r       <= dt_nxt;
    neg_r      <= neg_nxt;
    acc_r      <= acc_nxt;
    opa_r      <= opa_nxt;
    opb_r      <= opb_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  `PIDFD_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "accepted while busy")
  `PIDFD_ASSERT_NOW(a_result_from_sat, $rose(out_valid_r), $past(state_r == S_OSAT), "result outside final step")
  `PIDFD_ASSERT_NEXT(a_integral_cleared, state_r == S_ISET && ti_r == 16'd0, isum_r == 32'sd0, "integral not cleared")

endmodule
`default_nettype wire
